// ===== src/bpl_pkg.sv =====
// bpl_pkg: shared types and codes for the bounded positional list
// command and status codes, cell operation codes and the cell control struct
// no dependencies
package bpl_pkg;

    // index width that covers every supported capacity (up to 64 cells)
    localparam int LIST_IDX_W = 6;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_BACK  = 3'd1;
    localparam logic [2:0] CMD_INS_AFTER = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
    localparam logic [2:0] CMD_DEL_AT    = 3'd5;
    localparam logic [2:0] CMD_DUMP      = 3'd6;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_BAD_POS   = 2'd3;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                op;
        logic [LIST_IDX_W-1:0]   idx;
        logic [LIST_IDX_W-1:0]   tail;
    } cell_ctl_t;

endpackage

// ===== src/bpl_cell.sv =====
// bpl_cell: one storage cell of the list chain
// depends on bpl_pkg for the cell control struct and operation codes
module bpl_cell #(
    parameter int INDEX      = 0,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  bpl_pkg::cell_ctl_t      ctl,
    input  logic [DATA_WIDTH-1:0]   value_in,
    input  logic [DATA_WIDTH-1:0]   left_in,
    input  logic [DATA_WIDTH-1:0]   right_in,
    input  logic [DATA_WIDTH-1:0]   head_in,
    output logic [DATA_WIDTH-1:0]   data_out
);
    import bpl_pkg::*;

    localparam logic [LIST_IDX_W-1:0] MY_IDX = LIST_IDX_W'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INS:
            begin
                // cells past the gap take from the front side
                if (MY_IDX > ctl.idx)
                    data_next = left_in;
                else if (MY_IDX == ctl.idx)
                    data_next = value_in;
            end
            CELL_DEL:
            begin
                if (MY_IDX >= ctl.idx)
                    data_next = right_in;
            end
            CELL_ROT:
            begin
                // the tail takes the head so the list comes round whole
                if (MY_IDX < ctl.tail)
                    data_next = right_in;
                else if (MY_IDX == ctl.tail)
                    data_next = head_in;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

// ===== src/bpl_ctrl.sv =====
// bpl_ctrl: command decode, element count, dump sequencer and output register
// depends on bpl_pkg for codes and the cell control struct
module bpl_ctrl #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [2:0]              cmd,
    input  logic signed [31:0]      value,
    input  logic [4:0]              position,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              status,
    output logic signed [31:0]      element,
    output logic [5:0]              count,
    output logic                    last,
    input  logic [DATA_WIDTH-1:0]   head_in,
    output logic [DATA_WIDTH-1:0]   value_out,
    output bpl_pkg::cell_ctl_t      ctl
);
    import bpl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [LIST_IDX_W-1:0]  dump_reg, dump_next;
    logic                   out_valid_reg;
    logic [1:0]             status_reg, status_next;
    logic [31:0]            element_reg, element_next;
    logic [5:0]             count_out_reg;
    logic                   last_reg, last_next;

    logic                   slot_free;
    logic                   accept;
    logic                   load_out;
    logic                   full;
    logic                   empty;
    logic                   pos_bad;
    logic [63:0]            head_wide;
    logic [6:0]             count_wide;

    assign value_out  = DATA_WIDTH'(value);
    assign head_wide  = 64'(head_in);
    assign count_wide = 7'(count_next);

    assign full    = (count_reg == CAP_CNT);
    assign empty   = (count_reg == '0);
    assign pos_bad = (7'(position) >= 7'(count_reg));

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        ctl.op       = CELL_HOLD;
        ctl.idx      = '0;
        ctl.tail     = LIST_IDX_W'(count_reg - CNT_W'(1));
        load_out     = 1'b0;
        status_next  = ST_OK;
        element_next = '0;
        last_next    = 1'b1;
        count_next   = count_reg;
        state_next   = state_reg;
        dump_next    = dump_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load_out = 1'b1;
                    unique case (cmd) inside
                        CMD_INS_FRONT, CMD_INS_BACK:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else
                            begin
                                ctl.op     = CELL_INS;
                                ctl.idx    = (cmd == CMD_INS_FRONT) ? '0
                                                                    : LIST_IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_INS_AFTER:
                        begin
                            if (full)
                                status_next = ST_FULL;
                            else if (empty)
                                status_next = ST_EMPTY;
                            else if (pos_bad)
                                status_next = ST_BAD_POS;
                            else
                            begin
                                ctl.op     = CELL_INS;
                                ctl.idx    = LIST_IDX_W'(position) + LIST_IDX_W'(1);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEL_FRONT, CMD_DEL_BACK:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                ctl.op     = CELL_DEL;
                                ctl.idx    = (cmd == CMD_DEL_FRONT) ? '0 : ctl.tail;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_DEL_AT:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else if (pos_bad)
                                status_next = ST_BAD_POS;
                            else
                            begin
                                ctl.op     = CELL_DEL;
                                ctl.idx    = LIST_IDX_W'(position);
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_DUMP:
                        begin
                            if (empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                load_out   = 1'b0;
                                state_next = S_DUMP;
                                dump_next  = '0;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                // head goes out while the chain turns by one place
                if (slot_free)
                begin
                    ctl.op       = CELL_ROT;
                    load_out     = 1'b1;
                    element_next = head_wide[31:0];
                    last_next    = (dump_reg == ctl.tail);
                    dump_next    = dump_reg + LIST_IDX_W'(1);
                    if (dump_reg == ctl.tail)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dump_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dump_reg  <= dump_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg    <= status_next;
            element_reg   <= element_next;
            count_out_reg <= count_wide[5:0];
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign count     = count_out_reg;
    assign last      = last_reg;

endmodule

// ===== src/bounded_positional_list_top.sv =====
// bounded_positional_list_top: ordered list of signed values in a chain of cells
// depends on bpl_pkg, bpl_ctrl and bpl_cell
//
// usage
// - input channel (in_valid/in_ready) carries one command per transfer:
//   cmd, value (insert commands only) and position (insert-after, delete-at)
// - output channel (out_valid/out_ready) carries status, element, count, last
// - every edit command gives one result transfer with last set; the cells
//   that follow the edit point all shift by one place in the same cycle
// - a dump gives one result per stored element, front first, one per cycle while not
//   stalled, last set on the final one; the chain turns by one cell per element so it
//   is back in order once the dump ends; an empty dump gives one empty status
// - an edit result is loaded into the output register at its command transfer; the
//   first dump element is loaded in the cycle after that
// - throughput: one edit command per cycle while not stalled; a dump holds the input
//   channel until its final element is loaded, set by the single head tap of the chain
// - a stall on out_ready holds the output register and, through it, the
//   input channel and the dump sequence; nothing is dropped
// - reset empties the list (count zero); cell contents are left as they are
//   and only cells below the count are ever read
module bounded_positional_list_top #(
    parameter int CAPACITY   = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          cmd,
    input  logic signed [31:0]  value,
    input  logic [4:0]          position,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic signed [31:0]  element,
    output logic [5:0]          count,
    output logic                last
);
    import bpl_pkg::*;

    cell_ctl_t              cell_ctl;
    logic [DATA_WIDTH-1:0]  value_cell;
    logic [DATA_WIDTH-1:0]  cell_data [CAPACITY];

    // control, count and output register
    bpl_ctrl #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .element    (element),
        .count      (count),
        .last       (last),
        .head_in    (cell_data[0]),
        .value_out  (value_cell),
        .ctl        (cell_ctl)
    );

    // the chain: cell 0 is the front and takes the new value on its left; every other cell sees its neighbours
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;

        if (i == 0)
        begin : g_front
            assign left_d = value_cell;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_back
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        bpl_cell #(
            .INDEX      (i),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl),
            .value_in   (value_cell),
            .left_in    (left_d),
            .right_in   (right_d),
            .head_in    (cell_data[0]),
            .data_out   (cell_data[i])
        );
    end

`ifndef SYNTHESIS
    // the chain only turns during a dump, when no command can be taken
    a_rot_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctl.op == CELL_ROT) |-> !in_ready)
        else $error("chain rotation while input is ready");

    // cells are edited only by an accepted command
    a_edit_needs_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_ctl.op == CELL_INS || cell_ctl.op == CELL_DEL) |-> (in_valid && in_ready))
        else $error("cell edit without an input transfer");

    // while a dump element other than the final one waits, no command is taken
    a_dump_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !in_ready)
        else $error("input ready in the middle of a dump");
`endif

endmodule

// ===== dv/testbench.sv =====
// testbench: self-checking bench for bounded_positional_list_top
// directed command table then random traffic, scored by a queue-based list predictor
// depends on bpl_pkg and bounded_positional_list_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpl_pkg::*;

    localparam int CAPACITY        = 32;
    localparam int RANDOM_ITEMS    = 360;
    localparam int HOLD_OFF_CYCLES = 200;   // long receiver stall, well past the list's buffering
    localparam int DRAIN_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles before the run is abandoned

    // the spare command code has no name in the package
    localparam logic [2:0] CMD_SPARE = 3'd7;

    // one result transfer as the block should present it
    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] element;
        logic [5:0]         count;
        logic               last;
    } list_result_t;

    // one row of the directed table; fixed_exp marks rows whose single result is typed in
    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] value;
        logic [4:0]         pos;
        bit                 fixed_exp;
        logic [1:0]         status;
        logic [5:0]         count;
    } cmd_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         cmd = '0;
    logic signed [31:0] value = '0;
    logic [4:0]         position = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [5:0]         count;
    logic               last;

    // predictor state: the list contents, front at index 0
    logic signed [31:0] shadow_list[$];
    // results still owed by the block, oldest first
    list_result_t       pending_results[$];
    cmd_row_t           cmd_table[$];

    int                 errors = 0;
    int unsigned        send_gap_pct = 16;
    int unsigned        recv_stall_pct = 57;
    int                 hold_off_id = 0;

    bounded_positional_list_top #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .element   (element),
        .count     (count),
        .last      (last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // list predictor: applies one accepted command and queues the results it owes
    task automatic apply_list_cmd(input logic [2:0] op, input logic signed [31:0] val,
                                  input logic [4:0] pos);
        list_result_t res;
        logic [1:0]   st;
        int           n;
        begin
            n  = shadow_list.size();
            st = ST_OK;
            case (op)
                CMD_INS_FRONT, CMD_INS_BACK:
                begin
                    if (n >= CAPACITY)
                        st = ST_FULL;
                    else if (op == CMD_INS_FRONT)
                        shadow_list.push_front(val);
                    else
                        shadow_list.push_back(val);
                end
                CMD_INS_AFTER:
                begin
                    // full takes priority over the empty and range checks
                    if (n >= CAPACITY)
                        st = ST_FULL;
                    else if (n == 0)
                        st = ST_EMPTY;
                    else if (pos >= n)
                        st = ST_BAD_POS;
                    else
                        shadow_list.insert(pos + 1, val);
                end
                CMD_DEL_FRONT, CMD_DEL_BACK:
                begin
                    if (n == 0)
                        st = ST_EMPTY;
                    else if (op == CMD_DEL_FRONT)
                        void'(shadow_list.pop_front());
                    else
                        void'(shadow_list.pop_back());
                end
                CMD_DEL_AT:
                begin
                    // position zero takes the head away like a front delete
                    if (n == 0)
                        st = ST_EMPTY;
                    else if (pos >= n)
                        st = ST_BAD_POS;
                    else
                        shadow_list.delete(pos);
                end
                CMD_DUMP:
                begin
                    if (n == 0)
                        st = ST_EMPTY;
                    for (int k = 0; k < n; k++)
                    begin
                        res = '{status: ST_OK, element: shadow_list[k], count: 6'(n),
                                last: (k == n - 1)};
                        pending_results.push_back(res);
                    end
                end
                default:
                begin
                    // spare code: list untouched, plain ok status
                end
            endcase
            if (op != CMD_DUMP || n == 0)
            begin
                res = '{status: st, element: '0, count: 6'(shadow_list.size()), last: 1'b1};
                pending_results.push_back(res);
            end
        end
    endtask

    // offer one command, with random idle cycles in front, and hold it until the transfer
    task automatic send_list_cmd(input logic [2:0] op, input logic signed [31:0] val,
                                 input logic [4:0] pos);
        begin
            while ($urandom_range(99) < send_gap_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            cmd      <= op;
            value    <= val;
            position <= pos;
            do
                @(posedge clk);
            while (!in_ready);
            apply_list_cmd(op, val, pos);
        end
    endtask

    task automatic add_row(input logic [2:0] op, input logic signed [31:0] val,
                           input logic [4:0] pos, input bit fixed_exp,
                           input logic [1:0] st, input logic [5:0] cnt);
        cmd_row_t r;
        begin
            r = '{op: op, value: val, pos: pos, fixed_exp: fixed_exp, status: st, count: cnt};
            cmd_table.push_back(r);
        end
    endtask

    // score one result transfer against the oldest owed result
    task automatic score_result();
        list_result_t exp_res;
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with nothing owed: status %0d element %0d count %0d",
                       status, element, count);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.status)
                begin
                    $error("status: expected %0d, got %0d", exp_res.status, status);
                    errors++;
                end
                if (element !== exp_res.element)
                begin
                    $error("element: expected %0d, got %0d", exp_res.element, element);
                    errors++;
                end
                if (count !== exp_res.count)
                begin
                    $error("count: expected %0d, got %0d", exp_res.count, count);
                    errors++;
                end
                if (last !== exp_res.last)
                begin
                    $error("last: expected %0d, got %0d", exp_res.last, last);
                    errors++;
                end
            end
        end
    endtask

    // receiving side: scores every transfer, stalls at random, and does one long
    // hold-off whenever the stimulus asks for it
    initial
    begin : result_side
        int seen_hold_id;
        int hold_left;
        seen_hold_id = 0;
        hold_left    = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                score_result();
            if (seen_hold_id != hold_off_id)
            begin
                seen_hold_id = hold_off_id;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: gives up once neither channel has moved for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        logic [2:0]         op;
        logic signed [31:0] val;
        logic [4:0]         pos;
        bit                 filling;
        int unsigned        pick;
        list_result_t       typed_res;

        // directed table: op, value, position, typed?, status, count
        // empty list: every delete, insert-after and dump report empty
        add_row(CMD_DEL_FRONT, 32'sd0,         5'd0,  1, ST_EMPTY,   6'd0);
        add_row(CMD_DEL_BACK,  32'sh1234_5678, 5'd31, 1, ST_EMPTY,   6'd0);
        add_row(CMD_DEL_AT,    32'sd0,         5'd0,  1, ST_EMPTY,   6'd0);
        add_row(CMD_INS_AFTER, 32'sd5,         5'd0,  1, ST_EMPTY,   6'd0);
        add_row(CMD_DUMP,      32'sd0,         5'd0,  1, ST_EMPTY,   6'd0);
        add_row(CMD_SPARE,     -32'sd1,        5'd31, 1, ST_OK,      6'd0);
        // value extremes, insert after head and after tail, positions out of range
        add_row(CMD_INS_FRONT, 32'sh7fff_ffff, 5'd0,  1, ST_OK,      6'd1);
        add_row(CMD_INS_BACK,  32'sh8000_0000, 5'd0,  1, ST_OK,      6'd2);
        add_row(CMD_INS_AFTER, -32'sd1,        5'd0,  1, ST_OK,      6'd3);
        add_row(CMD_INS_AFTER, 32'sd0,         5'd3,  1, ST_BAD_POS, 6'd3);
        add_row(CMD_INS_AFTER, 32'sd0,         5'd31, 1, ST_BAD_POS, 6'd3);
        add_row(CMD_INS_AFTER, 32'sd0,         5'd2,  1, ST_OK,      6'd4);
        add_row(CMD_DUMP,      32'sd0,         5'd0,  0, ST_OK,      6'd0);
        add_row(CMD_DEL_AT,    32'sd0,         5'd31, 1, ST_BAD_POS, 6'd4);
        add_row(CMD_DEL_AT,    32'sd0,         5'd4,  1, ST_BAD_POS, 6'd4);
        // delete at position zero removes the head, then the tail by position
        add_row(CMD_DEL_AT,    32'sd0,         5'd0,  1, ST_OK,      6'd3);
        add_row(CMD_DEL_AT,    32'sd0,         5'd2,  1, ST_OK,      6'd2);
        add_row(CMD_INS_FRONT, 32'sh5555_5555, 5'd0,  1, ST_OK,      6'd3);
        add_row(CMD_INS_BACK,  32'shaaaa_aaaa, 5'd0,  1, ST_OK,      6'd4);
        add_row(CMD_DUMP,      32'sd0,         5'd0,  0, ST_OK,      6'd0);
        add_row(CMD_DEL_BACK,  32'sd0,         5'd0,  1, ST_OK,      6'd3);
        add_row(CMD_DEL_FRONT, 32'sd0,         5'd0,  1, ST_OK,      6'd2);
        add_row(CMD_DUMP,      32'sd0,         5'd0,  0, ST_OK,      6'd0);
        add_row(CMD_SPARE,     32'sd0,         5'd0,  1, ST_OK,      6'd2);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (cmd_table[i])
        begin
            send_list_cmd(cmd_table[i].op, cmd_table[i].value, cmd_table[i].pos);
            if (cmd_table[i].fixed_exp)
            begin
                // swap the predicted single result for the hand-written one
                void'(pending_results.pop_back());
                typed_res = '{status: cmd_table[i].status, element: '0,
                              count: cmd_table[i].count, last: 1'b1};
                pending_results.push_back(typed_res);
            end
        end

        // random part: fill and drain sweeps so the full and empty cases recur,
        // with dumps, spare codes and fully random commands mixed in
        filling = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_gap_pct   = 57;
                recv_stall_pct = 16;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                // no idling from here; the receiver first holds off for a long stretch
                send_gap_pct   = 0;
                recv_stall_pct = 0;
                hold_off_id++;
            end

            // turn the sweep round at the ends, lingering a little to hit full and empty
            if (shadow_list.size() >= CAPACITY && $urandom_range(3) == 0)
                filling = 1'b0;
            else if (shadow_list.size() == 0 && $urandom_range(3) == 0)
                filling = 1'b1;

            if ($urandom_range(7) == 0)
            begin
                case ($urandom_range(3))
                    0: val = 32'sh7fff_ffff;
                    1: val = 32'sh8000_0000;
                    2: val = 32'sd0;
                    default: val = -32'sd1;
                endcase
            end
            else
                val = $urandom;

            if (shadow_list.size() == 0 || $urandom_range(3) == 0)
                pos = 5'($urandom_range(31));
            else
                pos = 5'($urandom_range(shadow_list.size() - 1));

            pick = $urandom_range(99);
            if (pick < 7)
                op = CMD_DUMP;
            else if (pick < 9)
                op = CMD_SPARE;
            else if (pick < 12)
                op = 3'($urandom_range(7));
            else if (filling)
            begin
                case ($urandom_range(2))
                    0: op = CMD_INS_FRONT;
                    1: op = CMD_INS_BACK;
                    default: op = CMD_INS_AFTER;
                endcase
            end
            else
            begin
                case ($urandom_range(2))
                    0: op = CMD_DEL_FRONT;
                    1: op = CMD_DEL_BACK;
                    default: op = CMD_DEL_AT;
                endcase
            end
            send_list_cmd(op, val, pos);
        end
        in_valid <= 1'b0;

        // let every owed result arrive, then a few quiet cycles for stray transfers
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
